[src/lpab_pkg.sv]
package lpab_pkg;

  localparam int unsigned SAMPLE_COUNT_BITS = 24;
  localparam int unsigned MAX_LENGTH_BYTES  = 4;
  localparam int unsigned CMD_QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam int unsigned LENGTH_SIZE_W     = 3;

  localparam logic [LENGTH_SIZE_W-1:0] LENGTH_SIZE_RESET = 3'd4;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_LENGTH_SIZE = 1'b0;

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [1:0] {
    CMD_START,
    CMD_WARN,
    CMD_PAYLOAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]                   data_byte;
    logic [SAMPLE_COUNT_BITS-1:0] bytes_left;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_start_code;
    logic       truncated;
    logic       last;
  } out_t;

endpackage

[src/lpab_front.sv]
module lpab_front import lpab_pkg::*; #(
  parameter int unsigned MaxLengthBytes = MAX_LENGTH_BYTES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  in_t                      item_i,
  input  logic [LENGTH_SIZE_W-1:0] length_size_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o
);

  localparam int unsigned AccW = 8 * MaxLengthBytes;
  localparam int unsigned CmpW = (AccW > SAMPLE_COUNT_BITS) ? AccW : SAMPLE_COUNT_BITS;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DROP
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [2:0]               seen_q, seen_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [AccW-1:0]          rem_q, rem_d;

  logic [LENGTH_SIZE_W-1:0] eff_size;
  logic [AccW+7:0]          acc_wide;
  logic [AccW-1:0]          acc_shift;
  logic [AccW-1:0]          rem_dec;
  logic [2:0]               seen_inc;
  logic                     fits;

  always_comb begin
    eff_size = length_size_i;
    if (eff_size == '0) begin
      eff_size = LENGTH_SIZE_W'(1);
    end
    if (eff_size > LENGTH_SIZE_W'(MaxLengthBytes)) begin
      eff_size = LENGTH_SIZE_W'(MaxLengthBytes);
    end
  end

  assign acc_wide  = {acc_q, item_i.data_byte};
  assign acc_shift = acc_wide[AccW-1:0];
  assign rem_dec   = rem_q - AccW'(1);
  assign seen_inc  = seen_q + 3'd1;
  assign fits      = CmpW'(acc_shift) <= CmpW'(item_i.bytes_left);

  always_comb begin
    phase_d     = phase_q;
    seen_d      = seen_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_PAYLOAD;
    cmd_o.data  = item_i.data_byte;
    if (accept_i) begin
      unique case (phase_q)
        PH_LENGTH: begin
          acc_d  = acc_shift;
          seen_d = seen_inc;
          if (seen_inc >= eff_size) begin
            cmd_valid_o = 1'b1;
            if (fits) begin
              cmd_o.kind = CMD_START;
              rem_d      = acc_shift;
              phase_d    = (acc_shift != '0) ? PH_PAYLOAD : PH_LENGTH;
            end else begin
              cmd_o.kind = CMD_WARN;
              phase_d    = PH_DROP;
            end
            seen_d = '0;
            acc_d  = '0;
          end
        end
        PH_PAYLOAD: begin
          cmd_valid_o = 1'b1;
          rem_d       = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_LENGTH;
          end
        end
        default: begin
          phase_d = PH_DROP;
        end
      endcase
      if (item_i.bytes_left == '0) begin
        phase_d = PH_LENGTH;
        seen_d  = '0;
        acc_d   = '0;
        rem_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LENGTH;
      seen_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

endmodule

[src/lpab_cmd_fifo.sv]
module lpab_cmd_fifo import lpab_pkg::*; #(
  parameter int unsigned Depth = CMD_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic valid_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[src/lpab_back.sv]
module lpab_back import lpab_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output out_t out_o
);

  logic       out_valid_q;
  out_t       out_q, out_d;
  logic [1:0] sc_idx_q;
  logic       advance;
  logic       sc_done;

  assign advance   = cmd_valid_i && (!out_valid_q || pop_i);
  assign sc_done   = sc_idx_q == 2'd3;
  assign cmd_pop_o = advance && ((cmd_i.kind != CMD_START) || sc_done);
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_comb begin
    out_d = '0;
    unique case (cmd_i.kind)
      CMD_START: begin
        out_d.out_byte      = START_CODE[sc_idx_q];
        out_d.is_start_code = 1'b1;
        out_d.last          = sc_done;
      end
      CMD_WARN: begin
        out_d.truncated = 1'b1;
        out_d.last      = 1'b1;
      end
      CMD_PAYLOAD: begin
        out_d.out_byte = cmd_i.data;
        out_d.last     = 1'b1;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sc_idx_q    <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && (cmd_i.kind == CMD_START)) begin
        sc_idx_q <= sc_idx_q + 2'd1;
      end
    end
  end

endmodule

[src/length_prefix_to_annexb_converter.sv]
// Channel   Direction  Handshake           Word
// input     in         push / full         in_data_i  (data_byte, bytes_left)
// result    out        empty / pop         out_data_o (out_byte, is_start_code, truncated, last)
// config    in         APB psel / penable  length_size at byte address 0
//
// One input word is taken per cycle while the command queue has room.
// A completed length field yields four start code words, or one truncation warning if the
// length exceeds bytes_left; the back end sends one word per cycle unless pop stalls.
// Reset is asynchronous and active low; it empties the queue and the output register.
// A stalled pop holds the output register, the command queue fills, and full then stalls push.
module length_prefix_to_annexb_converter import lpab_pkg::*; #(
  parameter int unsigned MaxLengthBytes = MAX_LENGTH_BYTES,
  parameter int unsigned CmdQueueDepth  = CMD_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_data_i,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LENGTH_SIZE_W-1:0] length_size_q;
  logic                     accept;
  logic                     fifo_full;
  logic                     front_valid;
  cmd_t                     front_cmd;
  logic                     head_valid;
  cmd_t                     head_cmd;
  logic                     head_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LENGTH_SIZE) ? CFG_DATA_W'(length_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_size_q <= LENGTH_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH_SIZE)) begin
      length_size_q <= pwdata[LENGTH_SIZE_W-1:0];
    end
  end

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  lpab_front #(
    .MaxLengthBytes(MaxLengthBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .length_size_i(length_size_q),
    .cmd_valid_o  (front_valid),
    .cmd_o        (front_cmd)
  );

  lpab_cmd_fifo #(
    .Depth(CmdQueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_cmd),
    .pop_i  (head_pop),
    .data_o (head_cmd),
    .valid_o(head_valid),
    .full_o (fifo_full)
  );

  lpab_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (head_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_data_o)
  );

endmodule

[src/lpab_checker.sv]
module lpab_checker import lpab_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input out_t out_data_o
);

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  a_warn_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.truncated) |->
      (out_data_o.last && !out_data_o.is_start_code && (out_data_o.out_byte == 8'h00)))
    else $error("malformed truncation warning");

  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.is_start_code) |->
      (out_data_o.last ? (out_data_o.out_byte == 8'h01) : (out_data_o.out_byte == 8'h00)))
    else $error("wrong start code byte");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_data_o.is_start_code && !out_data_o.last) |=>
      ##0 (empty || out_data_o.is_start_code))
    else $error("start code interrupted");

endmodule

bind length_prefix_to_annexb_converter lpab_checker u_lpab_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_data_o(out_data_o)
);

[verif/annexb_stream_checker.sv]
module annexb_stream_checker import lpab_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  in_t                   in_data_i,
  input  logic                  empty,
  input  logic                  pop,
  input  out_t                  out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef enum logic [1:0] {
    SEEK_LENGTH,
    COPY_PAYLOAD,
    DROP_REST
  } conv_phase_e;

  logic [LENGTH_SIZE_W-1:0] length_size_q;
  conv_phase_e              phase_q;
  logic [2:0]               field_bytes_q;
  logic [31:0]              nal_len_q;
  logic [31:0]              payload_left_q;
  out_t                     annexb_words_q[$];
  int                       mismatches = 0;
  int                       words_seen = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [2:0] field_size(input logic [LENGTH_SIZE_W-1:0] ls);
    if (ls == 0) return 3'd1;
    if (ls > MAX_LENGTH_BYTES) return 3'(MAX_LENGTH_BYTES);
    return ls;
  endfunction

  function automatic out_t make_word(input logic [7:0] b, input logic sc, input logic tr,
                                     input logic lst);
    out_t w;
    w.out_byte      = b;
    w.is_start_code = sc;
    w.truncated     = tr;
    w.last          = lst;
    return w;
  endfunction

  task automatic clear_sample_state();
    phase_q        = SEEK_LENGTH;
    field_bytes_q  = '0;
    nal_len_q      = '0;
    payload_left_q = '0;
  endtask

  task automatic convert_byte(input in_t w);
    logic [31:0] len_next;
    len_next = {nal_len_q[23:0], w.data_byte};
    case (phase_q)
      SEEK_LENGTH: begin
        field_bytes_q = field_bytes_q + 3'd1;
        if (field_bytes_q >= field_size(length_size_q)) begin
          if (len_next <= 32'(w.bytes_left)) begin
            for (int k = 0; k < 4; k++) begin
              annexb_words_q = {annexb_words_q,
                                make_word(START_CODE[k], 1'b1, 1'b0, k == 3)};
            end
            payload_left_q = len_next;
            phase_q = (len_next != 0) ? COPY_PAYLOAD : SEEK_LENGTH;
          end else begin
            annexb_words_q = {annexb_words_q, make_word(8'h00, 1'b0, 1'b1, 1'b1)};
            phase_q = DROP_REST;
          end
          field_bytes_q = '0;
          nal_len_q     = '0;
        end else begin
          nal_len_q = len_next;
        end
      end
      COPY_PAYLOAD: begin
        annexb_words_q = {annexb_words_q, make_word(w.data_byte, 1'b0, 1'b0, 1'b1)};
        payload_left_q = payload_left_q - 32'd1;
        if (payload_left_q == 0) phase_q = SEEK_LENGTH;
      end
      default: begin
      end
    endcase
    if (w.bytes_left == 0) clear_sample_state();
  endtask

  task automatic check_word(input out_t got);
    out_t want;
    if (annexb_words_q.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected (%h)", words_seen, got));
    end else begin
      want = annexb_words_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("word %0d out_byte %h, expected %h", words_seen,
                                  got.out_byte, want.out_byte));
      if (got.is_start_code !== want.is_start_code)
        report_mismatch($sformatf("word %0d is_start_code %b, expected %b", words_seen,
                                  got.is_start_code, want.is_start_code));
      if (got.truncated !== want.truncated)
        report_mismatch($sformatf("word %0d truncated %b, expected %b", words_seen,
                                  got.truncated, want.truncated));
      if (got.last !== want.last)
        report_mismatch($sformatf("word %0d last %b, expected %b", words_seen,
                                  got.last, want.last));
    end
    words_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_size_q = LENGTH_SIZE_RESET;
      clear_sample_state();
      annexb_words_q.delete();
    end else begin
      if (pop && !empty) check_word(out_data_o);
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1] == REG_LENGTH_SIZE) begin
        length_size_q = pwdata[LENGTH_SIZE_W-1:0];
      end
      if (push && !full) convert_byte(in_data_i);
    end
    pending_o = annexb_words_q.size();
  end

endmodule

[verif/length_prefix_to_annexb_converter_tb.sv]
module length_prefix_to_annexb_converter_tb;
  import lpab_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 38;
  localparam logic [2:0] SIZE_PLAN [6] = '{3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd4};

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_t                   in_data_i = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_t                  out_data_o;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          mismatches;
  int          expected_words;
  int          cycles      = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        long_hold   = 1'b0;
  logic        hold_done   = 1'b0;
  int          hold_cnt    = 0;
  int          field_len   = LENGTH_SIZE_RESET;
  logic [7:0]  byte_q[$];
  logic [23:0] left_q[$];

  always #2 clk_i = ~clk_i;

  length_prefix_to_annexb_converter dut (
    .clk_i, .rst_ni, .push, .full, .in_data_i, .empty, .pop, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  annexb_stream_checker annexb_check (
    .clk_i, .rst_ni, .push, .full, .in_data_i, .empty, .pop, .out_data_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(mismatches), .pending_o(expected_words)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The long hold stalls the output once so that the block backs up into its input.
  always @(negedge clk_i) begin
    if (long_hold && !hold_done) begin
      pop = 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      pop = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push      = 1'b0;
      in_data_i = in_t'($urandom());
      @(negedge clk_i);
    end
    push      = 1'b1;
    in_data_i = w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_sample();
    in_t w;
    for (int i = 0; i < byte_q.size(); i++) begin
      w.data_byte  = byte_q[i];
      w.bytes_left = (left_q.size() == byte_q.size()) ? left_q[i] : 24'(byte_q.size() - 1 - i);
      send_word(w);
    end
    byte_q.delete();
    left_q.delete();
  endtask

  task automatic add_field(input logic [31:0] len);
    for (int i = field_len - 1; i >= 0; i--) byte_q = {byte_q, len[8*i +: 8]};
  endtask

  task automatic add_payload(input int n);
    repeat (n) byte_q = {byte_q, 8'($urandom_range(255))};
  endtask

  task automatic add_nals(input int n);
    int len;
    repeat (n) begin
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      add_field(len);
      add_payload(len);
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    push = 1'b0;
    while (expected_words != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_length_size(input logic [2:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_LENGTH_SIZE, 2'b00};
    pwdata  = ($urandom() & ~32'h7) | 32'(v);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    field_len = (v == 0) ? 1 : (v > MAX_LENGTH_BYTES) ? MAX_LENGTH_BYTES : v;
  endtask

  task automatic random_sample(output int counted);
    int kind;
    int len;
    int extra;
    kind  = $urandom_range(99);
    extra = 0;
    if (kind < 65) begin
      add_nals($urandom_range(1, 3));
    end else if (kind < 77) begin
      add_nals($urandom_range(0, 1));
      extra = $urandom_range(0, 3);
      if (field_len == 4 && $urandom_range(1) == 1) len = $urandom() | 32'h8000_0000;
      else len = extra + $urandom_range(1, 20);
      add_field(len);
      add_payload(extra);
    end else if (kind < 87) begin
      add_nals($urandom_range(0, 1));
      if (field_len > 1) add_payload($urandom_range(1, field_len - 1));
      else add_nals(1);
    end else if (kind < 94) begin
      len = $urandom_range(3, 8);
      add_field(len);
      add_payload($urandom_range(1, len - 1));
      for (int i = 1; i < byte_q.size(); i++) begin
        left_q = {left_q, 24'($urandom_range(256, 24'hFFFFFF))};
      end
      left_q = {left_q, 24'h0};
    end else begin
      add_payload($urandom_range(1, 6));
      for (int i = 1; i < byte_q.size(); i++) left_q = {left_q, 24'($urandom())};
      left_q = {left_q, 24'h0};
    end
    counted = byte_q.size() - extra;
    send_sample();
  endtask

  initial begin
    int sent;
    int n;
    tx_idle_pct = 26;
    rx_idle_pct = 63;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_field(32'd1);
    byte_q = {byte_q, 8'hFF};
    send_sample();
    add_field(32'd0);
    add_field(32'd1);
    byte_q = {byte_q, 8'h7E};
    send_sample();
    add_field(32'hFFFF_FFFF);
    byte_q = {byte_q, 8'h5A};
    send_sample();
    byte_q = {byte_q, 8'h00};
    byte_q = {byte_q, 8'h00};
    send_sample();
    // A long NAL whose sample ends early, with counts that disagree.
    add_field(32'h00F0_0000);
    byte_q = {byte_q, 8'hAA};
    byte_q = {byte_q, 8'h55};
    repeat (4) left_q = {left_q, 24'hFFFFFF};
    left_q = {left_q, 24'h800000};
    left_q = {left_q, 24'h000000};
    send_sample();
    wait_quiet();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 63;
        end
        1: begin
          tx_idle_pct = 63;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_length_size(SIZE_PLAN[seg]);
      if (seg == 4) long_hold = 1'b1;
      sent = 0;
      while (sent < SEG_ITEMS) begin
        random_sample(n);
        sent += n;
      end
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/lpab_pkg.sv
src/lpab_front.sv
src/lpab_cmd_fifo.sv
src/lpab_back.sv
src/length_prefix_to_annexb_converter.sv
src/lpab_checker.sv
verif/annexb_stream_checker.sv
verif/length_prefix_to_annexb_converter_tb.sv
